>>> sv/kif_pkg.sv
// ----------------------------------------------------------------------------
// kif_pkg
// Types and codes shared by the key-input FIFO peripheral.
// ----------------------------------------------------------------------------
package kif_pkg;

   // item function codes
   localparam logic [1:0] FUNC_INJECT = 2'd0;
   localparam logic [1:0] FUNC_READ   = 2'd1;
   localparam logic [1:0] FUNC_WRITE  = 2'd2;

   // register offsets
   localparam logic [7:0] OFS_STATUS  = 8'd0;
   localparam logic [7:0] OFS_DATA    = 8'd1;
   localparam logic [7:0] OFS_PEEK    = 8'd2;
   localparam logic [7:0] OFS_COUNT   = 8'd3;
   localparam logic [7:0] OFS_CONTROL = 8'd4;

   // status bit positions
   localparam int unsigned ST_NOT_EMPTY_BIT = 0;
   localparam int unsigned ST_FULL_BIT      = 1;
   localparam int unsigned ST_IRQ_BIT       = 2;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] reg_offset;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq_line;
   } rsp_type;

endpackage

>>> sv/key_input_fifo_registers.sv
// ----------------------------------------------------------------------------
// key_input_fifo_registers
// Key-input peripheral: ring FIFO of key codes behind a small register set.
// ----------------------------------------------------------------------------
//
//  channel | ports                                | beat
//  --------+--------------------------------------+-----------------------------
//  req     | req_valid, req_ready, req_payload    | inject key, bus read or write
//  rsp     | rsp_valid, rsp_ready, rsp_payload    | read data and irq line
//
//  Most beats load their result straight into the response register. A DATA or
//  PEEK read of a non-empty FIFO first does the synchronous key memory read of
//  the head entry, then registers the response; no request is taken meanwhile.
//  The response register frees itself when its beat is taken, so a new
//  request is taken in the same cycle the previous response drains.
//  Reset empties the FIFO and clears the irq enable; key memory is not cleared.
//
module key_input_fifo_registers #(
   parameter int unsigned FIFO_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  kif_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output kif_pkg::rsp_type rsp_payload
);

   localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_FETCH = 1'b1;

   logic [7:0]       key_mem [FIFO_DEPTH];
   logic [7:0]       mem_q_ff;

   logic             state_ff, state_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             irq_en_ff, irq_en_in;
   logic             rsp_valid_ff, rsp_valid_in;
   kif_pkg::rsp_type rsp_ff, rsp_in;
   logic             pend_irq_ff, pend_irq_in;

   logic             accept;
   logic             empty;
   logic             full;
   logic             mem_we;
   logic [7:0]       rd_imm;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CNT_FULL);
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      count_in     = count_ff;
      irq_en_in    = irq_en_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      pend_irq_in  = pend_irq_ff;
      mem_we       = 1'b0;
      rd_imm       = 8'd0;

      if (state_ff == ST_FETCH) begin
         // head key is back from memory
         state_in           = ST_IDLE;
         rsp_valid_in       = 1'b1;
         rsp_in.read_data   = mem_q_ff;
         rsp_in.irq_line    = pend_irq_ff;
      end else if (accept) begin
         case (req_payload.func)
            kif_pkg::FUNC_INJECT: begin
               if (!full) begin
                  mem_we    = 1'b1;
                  wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
                  count_in  = count_ff + 1'b1;
               end
            end
            kif_pkg::FUNC_READ: begin
               case (req_payload.reg_offset)
                  kif_pkg::OFS_STATUS: begin
                     rd_imm[kif_pkg::ST_NOT_EMPTY_BIT] = !empty;
                     rd_imm[kif_pkg::ST_FULL_BIT]      = full;
                     rd_imm[kif_pkg::ST_IRQ_BIT]       = irq_en_ff && !empty;
                  end
                  kif_pkg::OFS_DATA: begin
                     if (!empty) begin
                        state_in  = ST_FETCH;
                        rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
                        count_in  = count_ff - 1'b1;
                     end
                  end
                  kif_pkg::OFS_PEEK: begin
                     if (!empty) begin
                        state_in = ST_FETCH;
                     end
                  end
                  kif_pkg::OFS_COUNT: begin
                     rd_imm = 8'(count_ff);
                  end
                  default: begin
                     rd_imm = 8'd0;
                  end
               endcase
            end
            kif_pkg::FUNC_WRITE: begin
               if (req_payload.reg_offset == kif_pkg::OFS_CONTROL) begin
                  irq_en_in = req_payload.data_byte[0];
               end
            end
            default: begin
               rd_imm = 8'd0;
            end
         endcase

         pend_irq_in = irq_en_in && (count_in != '0);
         if (state_in == ST_IDLE) begin
            rsp_valid_in     = 1'b1;
            rsp_in.read_data = rd_imm;
            rsp_in.irq_line  = pend_irq_in;
         end
      end
   end

   // key memory: one write port, one registered read port at the head
   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[wr_ptr_ff] <= req_payload.data_byte;
      end
      mem_q_ff <= key_mem[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         irq_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         irq_en_ff    <= irq_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff      <= rsp_in;
      pend_irq_ff <= pend_irq_in;
   end

endmodule
